// File: rtl/tea1_pkg.sv
// Shared types, constants and round functions of the TEA1 keystream generator.
// Holds the S-box, the filter rows, the bit permutation and the frame expansion.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tea1_pkg;

    localparam int unsigned IV_W       = 64;
    localparam int unsigned KEY_W      = 32;
    localparam int unsigned KEY_IN_W   = 80;
    localparam int unsigned FN_W       = 32;
    localparam int unsigned COUNT_W    = 7;
    localparam int unsigned ROUND_W    = 6;
    localparam int unsigned FOLD_STEPS = 10;
    localparam int unsigned FOLD_W     = 4;

    // Configuration register indexes.
    localparam logic CFG_KEY_UPPER = 1'b0;
    localparam logic CFG_KEY_LOWER = 1'b1;

    localparam logic [31:0] IV_XOR_CONST = 32'h9672_4FA1;

    // Filter rows, index 0 in the lowest bits.
    localparam logic [7:0][15:0] LUT_LO = {
        16'h93E2, 16'hC671, 16'h974C, 16'h8C6B,
        16'h2BC6, 16'h29B5, 16'h85E9, 16'hDA86
    };
    localparam logic [7:0][15:0] LUT_HI = {
        16'h9C47, 16'hC62B, 16'hEC92, 16'h2B9C,
        16'hC671, 16'hE985, 16'h791A, 16'h85D6
    };

    localparam logic [7:0] SBOX [256] = '{
        8'h9B, 8'hF8, 8'h3B, 8'h72, 8'h75, 8'h62, 8'h88, 8'h22,
        8'hFF, 8'hA6, 8'h10, 8'h4D, 8'hA9, 8'h97, 8'hC3, 8'h7B,
        8'h9F, 8'h78, 8'hF3, 8'hB6, 8'hA0, 8'hCC, 8'h17, 8'hAB,
        8'h4A, 8'h41, 8'h8D, 8'h89, 8'h25, 8'h87, 8'hD3, 8'hE3,
        8'hCE, 8'h47, 8'h35, 8'h2C, 8'h6D, 8'hFC, 8'hE7, 8'h6A,
        8'hB8, 8'hB7, 8'hFA, 8'h8B, 8'hCD, 8'h74, 8'hEE, 8'h11,
        8'h23, 8'hDE, 8'h39, 8'h6C, 8'h1E, 8'h8E, 8'hED, 8'h30,
        8'h73, 8'hBE, 8'hBB, 8'h91, 8'hCA, 8'h69, 8'h60, 8'h49,
        8'h5F, 8'hB9, 8'hC0, 8'h06, 8'h34, 8'h2A, 8'h63, 8'h4B,
        8'h90, 8'h28, 8'hAC, 8'h50, 8'hE4, 8'h6F, 8'h36, 8'hB0,
        8'hA4, 8'hD2, 8'hD4, 8'h96, 8'hD5, 8'hC9, 8'h66, 8'h45,
        8'hC5, 8'h55, 8'hDD, 8'hB2, 8'hA1, 8'hA8, 8'hBF, 8'h37,
        8'h32, 8'h2B, 8'h3E, 8'hB5, 8'h5C, 8'h54, 8'h67, 8'h92,
        8'h56, 8'h4C, 8'h20, 8'h6B, 8'h42, 8'h9D, 8'hA7, 8'h58,
        8'h0E, 8'h52, 8'h68, 8'h95, 8'h09, 8'h7F, 8'h59, 8'h9C,
        8'h65, 8'hB1, 8'h64, 8'h5E, 8'h4F, 8'hBA, 8'h81, 8'h1C,
        8'hC2, 8'h0C, 8'h02, 8'hB4, 8'h31, 8'h5B, 8'hFD, 8'h1D,
        8'h0A, 8'hC8, 8'h19, 8'h8F, 8'h83, 8'h8A, 8'hCF, 8'h33,
        8'h9E, 8'h3A, 8'h80, 8'hF2, 8'hF9, 8'h76, 8'h26, 8'h44,
        8'hF1, 8'hE2, 8'hC4, 8'hF5, 8'hD6, 8'h51, 8'h46, 8'h07,
        8'h14, 8'h61, 8'hF4, 8'hC1, 8'h24, 8'h7A, 8'h94, 8'h27,
        8'h00, 8'hFB, 8'h04, 8'hDF, 8'h1F, 8'h93, 8'h71, 8'h53,
        8'hEA, 8'hD8, 8'hBD, 8'h3D, 8'hD0, 8'h79, 8'hE6, 8'h7E,
        8'h4E, 8'h9A, 8'hD7, 8'h98, 8'h1B, 8'h05, 8'hAE, 8'h03,
        8'hC7, 8'hBC, 8'h86, 8'hDB, 8'h84, 8'hE8, 8'hD1, 8'hF7,
        8'h16, 8'h21, 8'h6E, 8'hE5, 8'hCB, 8'hA3, 8'h1A, 8'hEC,
        8'hA2, 8'h7D, 8'h18, 8'h85, 8'h48, 8'hDA, 8'hAA, 8'hF0,
        8'h08, 8'hC6, 8'h40, 8'hAD, 8'h57, 8'h0D, 8'h29, 8'h82,
        8'h7C, 8'hE9, 8'h8C, 8'hFE, 8'hDC, 8'h0F, 8'h2D, 8'h3C,
        8'h2E, 8'hF6, 8'h15, 8'h2F, 8'hAF, 8'hE1, 8'hEB, 8'h3F,
        8'h99, 8'h43, 8'h13, 8'h0B, 8'hE0, 8'hA5, 8'h12, 8'h77,
        8'h5D, 8'hB3, 8'h38, 8'hD9, 8'hEF, 8'h5A, 8'h01, 8'h70
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FOLD,
        ST_ROUND,
        ST_OUT
    } t_state;

    // Datapath strobes from the sequencer.
    typedef struct packed {
        logic load;
        logic fold_en;
        logic round_en;
    } t_ctrl;

    // Each result bit picks one bit of its row with a 4-bit selector taken from
    // both bytes of the word, the window sliding one bit per result bit.
    function automatic logic [7:0] filter_word(input logic [15:0] w,
                                               input logic [7:0][15:0] lut);
        logic [7:0] lo;
        logic [7:0] hi;
        logic [3:0] sel;
        logic [7:0] res;
        lo = w[7:0];
        hi = w[15:8];
        res = '0;
        for (int b = 0; b < 8; b++) begin
            sel = {hi[(b + 2) % 8], hi[(b + 1) % 8], lo[b], lo[(b + 7) % 8]};
            res[b] = lut[b][sel];
        end
        return res;
    endfunction

    function automatic logic [7:0] permute_byte(input logic [7:0] v);
        return {v[3], v[0], v[4], v[7], v[1], v[5], v[6], v[2]};
    endfunction

    function automatic logic [63:0] expand_frame(input logic [31:0] fn);
        logic [31:0] x;
        logic [63:0] q;
        x = fn ^ IV_XOR_CONST;
        x = {x[23:0], x[31:24]};
        q = {fn, x};
        return {q[7:0], q[63:8]};
    endfunction

endpackage

`default_nettype wire

// File: rtl/tea1_key_step.sv
// One S-box feedback step of the key register, shared by key folding and rounds.
// Depends on tea1_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tea1_key_step (
    input  wire logic [31:0] i_acc,
    input  wire logic [7:0]  i_key_byte,
    output logic      [7:0]  o_sbox_out,
    output logic      [31:0] o_acc_next
);

    logic [7:0] w_index;

    assign w_index    = i_acc[31:24] ^ i_key_byte ^ i_acc[7:0];
    assign o_sbox_out = tea1_pkg::SBOX[w_index];
    assign o_acc_next = {i_acc[23:0], o_sbox_out};

endmodule

`default_nettype wire

// File: rtl/tea1_round.sv
// State register update of one round: two filtered words, a permuted byte and
// the key S-box output fed back. Depends on tea1_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tea1_round (
    input  wire logic [63:0] i_iv,
    input  wire logic [7:0]  i_sbox_out,
    output logic      [63:0] o_iv_next
);

    logic [7:0] w_mix;
    logic [7:0] w_fb;

    assign w_mix = tea1_pkg::filter_word(i_iv[23:8], tea1_pkg::LUT_LO);
    assign w_fb  = tea1_pkg::filter_word(i_iv[55:40], tea1_pkg::LUT_HI)
                 ^ i_iv[63:56]
                 ^ tea1_pkg::permute_byte(i_iv[39:32])
                 ^ i_sbox_out;

    // Shift up one byte, mix lands on bits 39..32, feedback fills the low byte.
    assign o_iv_next = {i_iv[55:32], i_iv[31:24] ^ w_mix, i_iv[23:0], w_fb};

endmodule

`default_nettype wire

// File: rtl/tea1_ctrl.sv
// Sequencer: key fold steps, round counting, byte counting and both handshakes.
// Depends on tea1_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tea1_ctrl #(
    parameter int unsigned MAX_BYTES    = 64,
    parameter int unsigned FIRST_ROUNDS = 54,
    parameter int unsigned NEXT_ROUNDS  = 19
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    input  wire logic [tea1_pkg::COUNT_W-1:0]    i_byte_count,
    output logic                                 o_s_tready,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic                                 o_m_tlast,
    output tea1_pkg::t_ctrl                      o_ctrl
);

    tea1_pkg::t_state r_state, n_state;
    logic [tea1_pkg::FOLD_W-1:0]  r_fold_cnt;
    logic [tea1_pkg::ROUND_W-1:0] r_round_left;
    logic [tea1_pkg::COUNT_W-1:0] r_bytes_left;
    logic [tea1_pkg::COUNT_W-1:0] w_count;
    logic                         w_in_acc;
    logic                         w_out_acc;

    assign w_in_acc  = i_s_tvalid && o_s_tready;
    assign w_out_acc = o_m_tvalid && i_m_tready;
    assign w_count   = (i_byte_count > tea1_pkg::COUNT_W'(MAX_BYTES))
                     ? tea1_pkg::COUNT_W'(MAX_BYTES) : i_byte_count;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tea1_pkg::ST_IDLE: begin
                if (w_in_acc && (w_count != '0)) begin
                    n_state = tea1_pkg::ST_FOLD;
                end
            end
            tea1_pkg::ST_FOLD: begin
                if (r_fold_cnt == '0) begin
                    n_state = tea1_pkg::ST_ROUND;
                end
            end
            tea1_pkg::ST_ROUND: begin
                if (r_round_left == tea1_pkg::ROUND_W'(1)) begin
                    n_state = tea1_pkg::ST_OUT;
                end
            end
            tea1_pkg::ST_OUT: begin
                if (w_out_acc) begin
                    n_state = (r_bytes_left != '0) ? tea1_pkg::ST_ROUND : tea1_pkg::ST_IDLE;
                end
            end
            default: n_state = tea1_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready      = (r_state == tea1_pkg::ST_IDLE);
        o_m_tvalid      = (r_state == tea1_pkg::ST_OUT);
        o_m_tlast       = (r_bytes_left == '0);
        o_ctrl.load     = w_in_acc;
        o_ctrl.fold_en  = (r_state == tea1_pkg::ST_FOLD);
        o_ctrl.round_en = (r_state == tea1_pkg::ST_ROUND);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= tea1_pkg::ST_IDLE;
            r_fold_cnt   <= '0;
            r_round_left <= '0;
            r_bytes_left <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                tea1_pkg::ST_IDLE: begin
                    if (w_in_acc) begin
                        r_fold_cnt   <= tea1_pkg::FOLD_W'(tea1_pkg::FOLD_STEPS - 1);
                        r_bytes_left <= w_count;
                        r_round_left <= '0;
                    end
                end
                tea1_pkg::ST_FOLD: begin
                    r_fold_cnt <= r_fold_cnt - 1'b1;
                    if (r_fold_cnt == '0) begin
                        r_round_left <= tea1_pkg::ROUND_W'(FIRST_ROUNDS);
                    end
                end
                tea1_pkg::ST_ROUND: begin
                    r_round_left <= r_round_left - 1'b1;
                    // count the byte in its last round, so tlast is ready when it is offered
                    if (r_round_left == tea1_pkg::ROUND_W'(1)) begin
                        r_bytes_left <= r_bytes_left - 1'b1;
                    end
                end
                tea1_pkg::ST_OUT: begin
                    if (w_out_acc && (r_bytes_left != '0)) begin
                        r_round_left <= tea1_pkg::ROUND_W'(NEXT_ROUNDS);
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/tea1_keystream_generator.sv
// TEA1 keystream generator top level: key registers, state and key datapath.
// Depends on tea1_pkg, tea1_ctrl, tea1_key_step and tea1_round.
//
// Usage:
//   Write the 80-bit key through the configuration port while the block is idle:
//   index 0 takes key bytes 0 and 1, index 1 takes key bytes 2 to 9.
//   Each input beat carries a frame number and a byte count (saturated to
//   MAX_BYTES). The block then sends that many keystream bytes on the master
//   side, tlast high on the final one. A zero count sends nothing.
//   Steps per request: accept, 10 key fold steps, FIRST_ROUNDS rounds before the
//   first byte and NEXT_ROUNDS before each later byte, one round per cycle
//   through the shared S-box step and round unit. Each byte is held on the
//   master side until the receiver takes it.
//   o_s_tready is high only while idle; one request is worked on at a time.
//   When the receiver stalls, the byte is held on o_m_tdata and the rounds wait.
//   Reset clears the key registers and returns the sequencer to idle.
`timescale 1ns / 1ps
`default_nettype none

module tea1_keystream_generator #(
    parameter int unsigned MAX_BYTES    = 64,
    parameter int unsigned FIRST_ROUNDS = 54,
    parameter int unsigned NEXT_ROUNDS  = 19
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [39:0] i_s_tdata,   // frame_number [31:0], byte_count [38:32], zero [39]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [7:0]  o_m_tdata,   // keystream_byte [7:0]
    output logic             o_m_tlast    // last_byte
);

    logic [15:0]                     r_key_upper;
    logic [63:0]                     r_key_lower;
    logic [tea1_pkg::IV_W-1:0]       r_iv;
    logic [tea1_pkg::KEY_W-1:0]      r_key;
    logic [tea1_pkg::KEY_IN_W-1:0]   r_fold_key;

    tea1_pkg::t_ctrl                 w_ctrl;
    logic [7:0]                      w_key_byte;
    logic [7:0]                      w_sbox_out;
    logic [tea1_pkg::KEY_W-1:0]      w_key_next;
    logic [tea1_pkg::IV_W-1:0]       w_iv_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_upper <= '0;
            r_key_lower <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tea1_pkg::CFG_KEY_UPPER: r_key_upper <= i_cfg_data[15:0];
                tea1_pkg::CFG_KEY_LOWER: r_key_lower <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tea1_ctrl #(
        .MAX_BYTES    (MAX_BYTES),
        .FIRST_ROUNDS (FIRST_ROUNDS),
        .NEXT_ROUNDS  (NEXT_ROUNDS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_byte_count (i_s_tdata[38:32]),
        .o_s_tready   (o_s_tready),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tlast    (o_m_tlast),
        .o_ctrl       (w_ctrl)
    );

    // key bytes enter the fold one per cycle, byte 0 first; rounds add none
    assign w_key_byte = w_ctrl.fold_en ? r_fold_key[79:72] : 8'h00;

    tea1_key_step u_key_step (
        .i_acc      (r_key),
        .i_key_byte (w_key_byte),
        .o_sbox_out (w_sbox_out),
        .o_acc_next (w_key_next)
    );

    tea1_round u_round (
        .i_iv       (r_iv),
        .i_sbox_out (w_sbox_out),
        .o_iv_next  (w_iv_next)
    );

    always_ff @(posedge i_clk) begin
        if (w_ctrl.load) begin
            r_iv       <= tea1_pkg::expand_frame(i_s_tdata[31:0]);
            r_key      <= '0;
            r_fold_key <= {r_key_upper, r_key_lower};
        end else if (w_ctrl.fold_en) begin
            r_key      <= w_key_next;
            r_fold_key <= {r_fold_key[71:0], 8'h00};
        end else if (w_ctrl.round_en) begin
            r_key <= w_key_next;
            r_iv  <= w_iv_next;
        end
    end

    assign o_m_tdata = r_iv[63:56];

    // never ready for input while a byte is on offer
    a_ready_valid_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("input ready while output valid");

    a_zero_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (i_s_tdata[38:32] == 7'd0)) |=> o_s_tready)
        else $error("zero byte count left the block busy");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast) |=> o_s_tready)
        else $error("block not idle after the last byte");

    a_more_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && !o_m_tlast) |=> (!o_m_tvalid && !o_s_tready))
        else $error("next byte offered without rounds in between");

endmodule

`default_nettype wire
